FILE: rtl/thm_pkg.sv
// ----------------------------------------------------------------------------
// thm_pkg
// Shared types and codes for the ternary min-heap queue: transaction
// payloads, operation codes and result status codes.
// ----------------------------------------------------------------------------
package thm_pkg;

  // operation requested by an input transaction
  typedef enum logic {
    ModeInsert  = 1'b0,
    ModeExtract = 1'b1
  } mode_e;

  // completion status of one operation
  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusFull  = 2'd1,
    StatusEmpty = 2'd2
  } status_e;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned OccWidth   = 11;

  // input transaction payload
  typedef struct packed {
    mode_e                        mode;
    logic signed [ValueWidth-1:0] item_value;
  } in_item_t;

  // output transaction payload
  typedef struct packed {
    status_e                      status;
    logic signed [ValueWidth-1:0] min_value;
    logic [OccWidth-1:0]          occupancy;
  } out_item_t;

endpackage

FILE: rtl/thm_ram.sv
// ----------------------------------------------------------------------------
// thm_ram
// Heap entry store: one write port and one read port with registered
// read data. Contents are undefined until written.
// ----------------------------------------------------------------------------
module thm_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: rtl/thm_cmp.sv
// ----------------------------------------------------------------------------
// thm_cmp
// Shared signed magnitude comparator used by every sift step.
// ----------------------------------------------------------------------------
module thm_cmp #(
  parameter int unsigned WIDTH = 32
) (
  input  logic signed [WIDTH-1:0] a_i,
  input  logic signed [WIDTH-1:0] b_i,
  output logic                    lt_o
);

  // strict signed less-than, equal values never swap
  assign lt_o = (a_i < b_i);

endmodule

FILE: rtl/ternary_min_heap_queue_core.sv
// ----------------------------------------------------------------------------
// ternary_min_heap_queue_core
// Min-priority queue held as a complete ternary heap in a RAM with one read
// and one write port, maintained by a small sequencer around one comparator.
// ----------------------------------------------------------------------------
// Channels: in_valid_i/in_ready_o/in_item_i takes an insert or an extract;
//   each gives one out_valid_o/out_ready_i/out_item_o transaction with status,
//   extracted value (zero otherwise) and resulting occupancy. One operation is
//   in flight at a time; in_ready_o is high only while the sequencer is idle.
// Sequence: a full insert or an empty extract goes straight to the result;
//   an insert sifts up through address, read and compare per parent; an extract
//   reads the root and the last entry, then per level reads each existing child
//   and compares, stopping at a leaf. At the default capacity the heap has 7
//   levels; the next operation is accepted once the sequencer is back in idle.
// A stalled receiver holds the result in the output register while the next
//   operation runs; that result then waits until the register is free.
// Reset empties the queue at once; RAM contents need no clearing since only
//   positions below the occupancy are ever read.
// ----------------------------------------------------------------------------
module ternary_min_heap_queue_core #(
  parameter int unsigned CAPACITY   = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  thm_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output thm_pkg::out_item_t  out_item_o
);

  // count, position, child-index and RAM address widths
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = $clog2(CAPACITY + 2);
  localparam int unsigned XW = $clog2(3 * CAPACITY + 2);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  // reciprocal of three, exact for every position operand below 2**PW
  localparam int unsigned RecipInt = ((1 << (PW + 1)) + 2) / 3;
  localparam logic [PW:0] RecipMul = (PW + 1)'(RecipInt);

  typedef enum logic [3:0] {
    StIdle,
    StUpAddr,
    StUpRead,
    StUpCmp,
    StExRoot,
    StExLast,
    StExTake,
    StDnIdx,
    StDnR0,
    StDnR1,
    StDnR2,
    StDnR3,
    StDnCmp,
    StPlace,
    StResult
  } state_e;

  state_e                     state_q, state_d;
  logic [CW-1:0]              count_q, count_d;
  logic [PW-1:0]              hole_q, hole_d;
  logic [PW-1:0]              parent_q, parent_d;
  logic [XW-1:0]              first_q, first_d;
  logic signed [DATA_WIDTH-1:0] val_q, val_d;
  logic signed [DATA_WIDTH-1:0] best_q, best_d;
  logic [PW-1:0]              best_idx_q, best_idx_d;
  logic signed [DATA_WIDTH-1:0] min_q, min_d;
  thm_pkg::status_e           status_q, status_d;
  thm_pkg::out_item_t         out_q, out_d;
  logic                       out_valid_q, out_valid_d;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [DATA_WIDTH-1:0]      ram_wdata;
  logic [AW-1:0]              ram_raddr;
  logic [DATA_WIDTH-1:0]      ram_rdata;
  logic signed [DATA_WIDTH-1:0] rdata_s;

  logic signed [DATA_WIDTH-1:0] cmp_a, cmp_b;
  logic                       cmp_lt;

  logic [PW-1:0]              up_pos;
  logic [2*PW:0]              parent_prod;
  logic [XW-1:0]              count_x;

  // heap store
  thm_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rdata_s = $signed(ram_rdata);

  // shared comparator operand selection
  always_comb begin
    cmp_a = rdata_s;
    cmp_b = best_q;
    case (state_q)
      StUpCmp: begin
        cmp_a = val_q;
        cmp_b = rdata_s;
      end
      StDnCmp: begin
        cmp_a = best_q;
        cmp_b = val_q;
      end
      default: begin
        cmp_a = rdata_s;
        cmp_b = best_q;
      end
    endcase
  end

  thm_cmp #(
    .WIDTH (DATA_WIDTH)
  ) u_cmp (
    .a_i  (cmp_a),
    .b_i  (cmp_b),
    .lt_o (cmp_lt)
  );

  // parent index (i+1)/3 by reciprocal multiply
  assign up_pos      = hole_q + PW'(1);
  assign parent_prod = (2 * PW + 1)'(up_pos) * (2 * PW + 1)'(RecipMul);
  assign count_x     = XW'(count_q);

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // sequencer next-state logic
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    hole_d      = hole_q;
    parent_d    = parent_q;
    first_d     = first_q;
    val_d       = val_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    min_d       = min_q;
    status_d    = status_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we      = 1'b0;
    ram_waddr   = AW'(hole_q - PW'(1));
    ram_wdata   = val_q;
    ram_raddr   = '0;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          min_d    = '0;
          status_d = thm_pkg::StatusOk;
          if (in_item_i.mode == thm_pkg::ModeInsert) begin
            if (count_q == CW'(CAPACITY)) begin
              status_d = thm_pkg::StatusFull;
              state_d  = StResult;
            end else begin
              count_d = count_q + CW'(1);
              hole_d  = PW'(count_q) + PW'(1);
              val_d   = DATA_WIDTH'($signed(in_item_i.item_value));
              state_d = (count_q == '0) ? StPlace : StUpAddr;
            end
          end else begin
            if (count_q == '0) begin
              status_d = thm_pkg::StatusEmpty;
              state_d  = StResult;
            end else begin
              state_d = StExRoot;
            end
          end
        end
      end

      // sift up: one level per pass through address, read and compare
      StUpAddr: begin
        parent_d = parent_prod[2*PW:PW+1];
        state_d  = StUpRead;
      end
      StUpRead: begin
        ram_raddr = AW'(parent_q - PW'(1));
        state_d   = StUpCmp;
      end
      StUpCmp: begin
        if (cmp_lt) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          hole_d    = parent_q;
          state_d   = (parent_q == PW'(1)) ? StPlace : StUpAddr;
        end else begin
          state_d = StPlace;
        end
      end

      // extract: fetch root and last entry
      StExRoot: begin
        ram_raddr = '0;
        state_d   = StExLast;
      end
      StExLast: begin
        ram_raddr = AW'(count_q - CW'(1));
        min_d     = rdata_s;
        state_d   = StExTake;
      end
      StExTake: begin
        val_d   = rdata_s;
        count_d = count_q - CW'(1);
        hole_d  = PW'(1);
        state_d = StDnIdx;
      end

      // sift down: scan existing children, then compare with moving entry
      StDnIdx: begin
        first_d = (XW'(hole_q) << 1) + XW'(hole_q) - XW'(1);
        state_d = StDnR0;
      end
      StDnR0: begin
        if (first_q > count_x) begin
          state_d = StPlace;
        end else begin
          ram_raddr = AW'(first_q - XW'(1));
          state_d   = StDnR1;
        end
      end
      StDnR1: begin
        best_d     = rdata_s;
        best_idx_d = PW'(first_q);
        if ((first_q + XW'(1)) <= count_x) begin
          ram_raddr = AW'(first_q);
          state_d   = StDnR2;
        end else begin
          state_d = StDnCmp;
        end
      end
      StDnR2: begin
        if (cmp_lt) begin
          best_d     = rdata_s;
          best_idx_d = PW'(first_q + XW'(1));
        end
        if ((first_q + XW'(2)) <= count_x) begin
          ram_raddr = AW'(first_q + XW'(1));
          state_d   = StDnR3;
        end else begin
          state_d = StDnCmp;
        end
      end
      StDnR3: begin
        if (cmp_lt) begin
          best_d     = rdata_s;
          best_idx_d = PW'(first_q + XW'(2));
        end
        state_d = StDnCmp;
      end
      StDnCmp: begin
        if (cmp_lt) begin
          ram_we    = 1'b1;
          ram_wdata = best_q;
          hole_d    = best_idx_q;
          state_d   = StDnIdx;
        end else begin
          state_d = StPlace;
        end
      end

      // drop the moving entry into its final slot
      StPlace: begin
        ram_we    = 1'b1;
        ram_wdata = val_q;
        state_d   = StResult;
      end

      // load the output register once it is free
      StResult: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.status    = status_q;
          out_d.min_value = thm_pkg::ValueWidth'(min_q);
          out_d.occupancy = thm_pkg::OccWidth'(count_q);
          out_valid_d     = 1'b1;
          state_d         = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      hole_q      <= '0;
      parent_q    <= '0;
      first_q     <= '0;
      val_q       <= '0;
      best_q      <= '0;
      best_idx_q  <= '0;
      min_q       <= '0;
      status_q    <= thm_pkg::StatusOk;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      hole_q      <= hole_d;
      parent_q    <= parent_d;
      first_q     <= first_d;
      val_q       <= val_d;
      best_q      <= best_d;
      best_idx_q  <= best_idx_d;
      min_q       <= min_d;
      status_q    <= status_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  // occupancy stays within capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("occupancy above capacity");

  // a refused insert reports a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status == thm_pkg::StatusFull) |->
    (out_item_o.occupancy == thm_pkg::OccWidth'(CAPACITY) && out_item_o.min_value == '0))
    else $error("full status with wrong occupancy or value");

  // an empty extract reports an empty queue and no value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status == thm_pkg::StatusEmpty) |->
    (out_item_o.occupancy == '0 && out_item_o.min_value == '0))
    else $error("empty status with entries or value");

  // one operation at a time: accepted transaction closes the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while busy");

  // the store is never written while idle or in the result state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q != StIdle && state_q != StResult))
    else $error("heap store written outside a sift");

endmodule

FILE: dv/tb_ternary_min_heap_queue_core.sv
// ----------------------------------------------------------------------------
// tb_ternary_min_heap_queue_core
// Self-checking bench for the ternary min-heap queue. A scoreboard keeps its
// own heap and element count, predicts status, extracted value and
// occupancy for every accepted transaction, and compares each result in order.
// Stimulus covers empty and full queues, extreme and equal values and deep
// sifts, with bursty input traffic and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_ternary_min_heap_queue_core;

  localparam int unsigned HeapDepth  = 1024;
  localparam int unsigned CycleLimit = 1000000;
  localparam logic signed [thm_pkg::ValueWidth-1:0] MaxValue = 32'sh7fff_ffff;
  localparam logic signed [thm_pkg::ValueWidth-1:0] MinValue = 32'sh8000_0000;

  // heap predictor and in-order result checker
  class heap_scoreboard;
    logic signed [thm_pkg::ValueWidth-1:0] heap_mem [1:HeapDepth];
    int unsigned                  count;
    thm_pkg::out_item_t           expected_results [$];
    int unsigned                  error_count;

    // apply one accepted operation to the shadow heap and queue its result
    function void record_request(thm_pkg::in_item_t req);
      int unsigned                  pos;
      int unsigned                  up;
      int unsigned                  first;
      int unsigned                  best;
      logic signed [thm_pkg::ValueWidth-1:0] tmp;
      bit                           done;
      thm_pkg::out_item_t           want;
      want.status    = thm_pkg::StatusOk;
      want.min_value = '0;
      if (req.mode == thm_pkg::ModeInsert) begin
        if (count >= HeapDepth) begin
          want.status = thm_pkg::StatusFull;
        end else begin
          // append and sift up, no swap on equality
          count++;
          heap_mem[count] = req.item_value;
          pos  = count;
          done = 1'b0;
          while (pos > 1 && !done) begin
            up = (pos + 1) / 3;
            if (heap_mem[pos] < heap_mem[up]) begin
              tmp           = heap_mem[pos];
              heap_mem[pos] = heap_mem[up];
              heap_mem[up]  = tmp;
              pos           = up;
            end else begin
              done = 1'b1;
            end
          end
        end
      end else begin
        if (count == 0) begin
          want.status = thm_pkg::StatusEmpty;
        end else begin
          // pop root, move last entry up and sift it down
          want.min_value = heap_mem[1];
          heap_mem[1]    = heap_mem[count];
          count--;
          pos  = 1;
          done = 1'b0;
          while (!done) begin
            first = 3 * pos - 1;
            if (first > count) begin
              done = 1'b1;
            end else begin
              // only existing children take part
              best = first;
              if (first + 1 <= count && heap_mem[first + 1] < heap_mem[best]) best = first + 1;
              if (first + 2 <= count && heap_mem[first + 2] < heap_mem[best]) best = first + 2;
              if (heap_mem[best] < heap_mem[pos]) begin
                tmp            = heap_mem[pos];
                heap_mem[pos]  = heap_mem[best];
                heap_mem[best] = tmp;
                pos            = best;
              end else begin
                done = 1'b1;
              end
            end
          end
        end
      end
      want.occupancy = count[thm_pkg::OccWidth-1:0];
      expected_results.push_back(want);
    endfunction

    // compare one result transaction with the oldest expectation
    function void check_response(thm_pkg::out_item_t got);
      thm_pkg::out_item_t want;
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: status %0d value %0d occupancy %0d",
                   got.status, got.min_value, got.occupancy);
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status || got.min_value !== want.min_value ||
            got.occupancy !== want.occupancy) begin
          error_count++;
          if (error_count <= 10)
            $display({"mismatch: expected status %0d value %0d occupancy %0d, ",
                      "got status %0d value %0d occupancy %0d"},
                     want.status, want.min_value, want.occupancy,
                     got.status, got.min_value, got.occupancy);
        end
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  thm_pkg::in_item_t  in_item_i;
  logic               out_valid_o;
  logic               out_ready_i;
  thm_pkg::out_item_t out_item_o;

  heap_scoreboard sb;
  int unsigned    burst_left;
  int unsigned    gap_max;
  int unsigned    stall_pct;
  int unsigned    stall_left;
  int unsigned    cycle_count;

  ternary_min_heap_queue_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // receiver: ready drops in runs of random length
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 7);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_response(out_item_o);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // value mix: full range, a narrow band for ties, and the extremes
  function automatic logic signed [thm_pkg::ValueWidth-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $urandom;
    if (sel < 8) return $signed($urandom_range(0, 15)) - 8;
    case ($urandom_range(0, 3))
      0:       return MaxValue;
      1:       return MinValue;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic thm_pkg::mode_e pick_mode(int unsigned insert_pct);
    return ($urandom_range(0, 99) < insert_pct) ? thm_pkg::ModeInsert : thm_pkg::ModeExtract;
  endfunction

  // drive one transaction, note it once accepted, then maybe leave a gap
  task automatic send_item(input thm_pkg::mode_e op,
                           input logic signed [thm_pkg::ValueWidth-1:0] value);
    in_valid_i <= 1'b1;
    in_item_i  <= {op, value};
    do @(posedge clk_i); while (!in_ready_o);
    sb.record_request(in_item_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gap_max != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  initial begin
    sb          = new();
    burst_left  = 0;
    gap_max     = 0;
    stall_pct   = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty extract, extremes, ties, drain past empty
    send_item(thm_pkg::ModeExtract, '1);
    send_item(thm_pkg::ModeInsert, MaxValue);
    send_item(thm_pkg::ModeInsert, MinValue);
    send_item(thm_pkg::ModeInsert, '0);
    send_item(thm_pkg::ModeInsert, '1);
    send_item(thm_pkg::ModeInsert, 32'sd5);
    send_item(thm_pkg::ModeInsert, 32'sd5);
    send_item(thm_pkg::ModeInsert, 32'sd5);
    send_item(thm_pkg::ModeInsert, 32'sd1);
    send_item(thm_pkg::ModeInsert, 32'sh5555_5555);
    send_item(thm_pkg::ModeInsert, 32'shaaaa_aaaa);
    repeat (11) send_item(thm_pkg::ModeExtract, $urandom);

    // random build-up with moderate idling on both sides
    gap_max   = 4;
    stall_pct = 30;
    repeat (150) send_item(pick_mode(70), pick_value());

    // fill to capacity, first stretch without idling, then refused inserts
    gap_max   = 0;
    stall_pct = 0;
    repeat (300) send_item(thm_pkg::ModeInsert, pick_value());
    gap_max   = 3;
    stall_pct = 15;
    while (sb.count < HeapDepth) send_item(thm_pkg::ModeInsert, pick_value());
    repeat (4) send_item(thm_pkg::ModeInsert, pick_value());

    // deep extracts from a large heap under heavy receiver stalls
    gap_max   = 8;
    stall_pct = 60;
    repeat (400) send_item(pick_mode(20), pick_value());

    // drain outstanding results
    in_valid_i <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (sb.error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
